@@ src/stg_pkg.sv @@
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types, constants and the quarter-wave sine function for the sine
// tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 18;
  localparam int VOL_W       = 15;
  localparam int PITCH_W     = 12;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE_VOLUME = 4'd1;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 15'd3000;

  // tone limits and start value in whole Hz
  localparam int FREQ_MAX_HZ   = 880;
  localparam int FREQ_MIN_HZ   = 220;
  localparam int FREQ_RESET_HZ = 440;

  // table entries are Q30, 0 .. 2^30
  localparam int     Q30_W       = 31;
  localparam int     Q30_FRAC    = 30;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic {
    CMD_GENERATE = 1'b0,
    CMD_PITCH    = 1'b1
  } cmd_t;

  // entries of the state memory
  typedef enum logic {
    ENTRY_PHASE = 1'b0,
    ENTRY_FREQ  = 1'b1
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FREQ,
    ST_RD_PHASE,
    ST_LOOKUP,
    ST_ADDR,
    ST_SCALE,
    ST_FINISH
  } state_t;

  // t * x^2 in Q30, truncating toward zero after each product
  function automatic longint taylor_pow2(input longint t, input longint x);
    longint p;
    p = (t * x) / ONE_Q30;
    return (p * x) / ONE_Q30;
  endfunction

  // Taylor series to the x^15 term, truncating toward zero at every step
  function automatic longint sine_q30(input longint x);
    longint term;
    longint sum;
    term = x;
    sum  = x;
    term = -taylor_pow2(term, x) / 64'sd6;
    sum  = sum + term;
    term = -taylor_pow2(term, x) / 64'sd20;
    sum  = sum + term;
    term = -taylor_pow2(term, x) / 64'sd42;
    sum  = sum + term;
    term = -taylor_pow2(term, x) / 64'sd72;
    sum  = sum + term;
    term = -taylor_pow2(term, x) / 64'sd110;
    sum  = sum + term;
    term = -taylor_pow2(term, x) / 64'sd156;
    sum  = sum + term;
    term = -taylor_pow2(term, x) / 64'sd210;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return sum;
  endfunction

endpackage

@@ src/stg_in_if.sv @@
// ----------------------------------------------------------------------------
// stg_in_if
// Command channel: generate a frame or adjust the pitch.
// ----------------------------------------------------------------------------
interface stg_in_if;
  import stg_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [PITCH_W-1:0] pitch_up;
  logic [PITCH_W-1:0] pitch_down;

  modport source (output valid, command, pitch_up, pitch_down, input ready);
  modport sink   (input valid, command, pitch_up, pitch_down, output ready);
endinterface

@@ src/stg_out_if.sv @@
// ----------------------------------------------------------------------------
// stg_out_if
// Stereo sample channel.
// ----------------------------------------------------------------------------
interface stg_out_if;
  import stg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

@@ src/stg_state_mem.sv @@
// ----------------------------------------------------------------------------
// stg_state_mem
// Two-entry state memory (phase, frequency), one write and one registered
// read port. Entries read their reset value until first written.
// ----------------------------------------------------------------------------
module stg_state_mem #(
  parameter int               DATA_W    = 32,
  parameter logic [DATA_W-1:0] FREQ_INIT = '0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stg_pkg::entry_t     rd_addr,
  input  logic                wr_en,
  input  stg_pkg::entry_t     wr_addr,
  input  logic [DATA_W-1:0]   wr_data,
  output logic [DATA_W-1:0]   rd_data
);
  import stg_pkg::*;

  logic [DATA_W-1:0] mem_r [2];
  logic [1:0]        valid_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] init_val;

  assign init_val = (rd_addr == ENTRY_FREQ) ? FREQ_INIT : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : init_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/stg_sine_rom.sv @@
// ----------------------------------------------------------------------------
// stg_sine_rom
// Quarter-wave sine ROM, DEPTH+1 entries in Q30, registered read.
// ----------------------------------------------------------------------------
module stg_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic [$clog2(DEPTH+1)-1:0]    rd_addr,
  output logic [stg_pkg::Q30_W-1:0]     rd_data
);
  import stg_pkg::*;

  localparam longint DEPTH_L = longint'(DEPTH);

  typedef logic [Q30_W-1:0] rom_t [0:DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    int   k;
    for (k = 0; k <= DEPTH; k++) begin
      r[k] = Q30_W'(sine_q30((longint'(k) * HALF_PI_Q30) / DEPTH_L));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [Q30_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= SINE_ROM[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/stg_divider.sv @@
// ----------------------------------------------------------------------------
// stg_divider
// Restoring divider, one quotient bit per cycle. Keeps the low QUO_W bits
// of the quotient; a zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module stg_divider #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 18,
  parameter int QUO_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = (den_r == '0) ? '0 : quo_r;

endmodule

@@ src/sine_tone_generator_unit.sv @@
// ----------------------------------------------------------------------------
// sine_tone_generator_unit
// Direct digital synthesis sine tone: phase accumulator, quarter-wave ROM,
// volume scaling and pitch adjust.
// ----------------------------------------------------------------------------
// A generate beat returns one stereo frame: the sine of the current phase from
// a quarter-wave ROM, scaled by tone_volume and truncated toward zero, on both
// channels; the phase then advances by frequency / sample_rate. A pitch beat
// raises the frequency (clamp 880 Hz), then lowers it (clamp 220 Hz), and
// returns nothing. Phase and frequency live in a two-entry state memory that
// is read, updated and written back per beat. One beat is worked on at a
// time. A generate beat waits for the bit-serial divider that computes the
// phase step, one quotient bit per cycle over the PHASE_BITS + 10 dividend
// bits, and for the output register to be free. A finished frame waits in
// the output register while the next beat is taken in.
// ----------------------------------------------------------------------------
module sine_tone_generator_unit #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32,
  parameter int FREQ_FRAC_BITS   = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  stg_in_if.sink                             in_beat,
  stg_out_if.source                          out_beat,
  input  logic                               cfg_we,
  input  logic [stg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [stg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import stg_pkg::*;

  localparam int FREQ_W  = $clog2((FREQ_MAX_HZ << FREQ_FRAC_BITS) + 1);
  localparam int SUM_W   = ((FREQ_W > PITCH_W) ? FREQ_W : PITCH_W) + 1;
  localparam int DATA_W  = (PHASE_BITS > FREQ_W) ? PHASE_BITS : FREQ_W;
  localparam int SHIFT_W = PHASE_BITS - FREQ_FRAC_BITS;
  localparam int NUM_W   = FREQ_W + SHIFT_W;
  localparam int IDX_W   = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TOP_W   = 16;
  localparam int MUL_W   = Q30_W + VOL_W;

  localparam logic [SUM_W-1:0]  FREQ_MAX  = SUM_W'(FREQ_MAX_HZ << FREQ_FRAC_BITS);
  localparam logic [SUM_W-1:0]  FREQ_MIN  = SUM_W'(FREQ_MIN_HZ << FREQ_FRAC_BITS);
  localparam logic [DATA_W-1:0] FREQ_INIT = DATA_W'(FREQ_RESET_HZ << FREQ_FRAC_BITS);
  localparam logic [IDX_W-1:0]  QUAD1     = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]  QUAD2     = IDX_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]  QUAD3     = IDX_W'(3 * SINE_TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] DEPTH_A   = ADDR_W'(SINE_TABLE_DEPTH);
  localparam logic [TOP_W+IDX_W-1:0] IDX_SCALE = (TOP_W + IDX_W)'(4 * SINE_TABLE_DEPTH);

  state_t state_r, state_nxt;

  // configuration
  logic [RATE_W-1:0] rate_r;
  logic [VOL_W-1:0]  vol_r;

  // beat in flight
  logic               cmd_r;
  logic [PITCH_W-1:0] up_r;
  logic [PITCH_W-1:0] down_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [IDX_W-1:0]   idx_r;
  logic               neg_r;
  logic [MUL_W-1:0]   prod_r;

  // output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;

  logic                in_accept;
  logic                out_free;
  logic                out_load;

  entry_t              mem_rd_addr;
  logic                mem_wr_en;
  entry_t              mem_wr_addr;
  logic [DATA_W-1:0]   mem_wr_data;
  logic [DATA_W-1:0]   mem_rd_data;

  logic                div_start;
  logic                div_done;
  logic [PHASE_BITS-1:0] div_quo;

  logic [ADDR_W-1:0]   rom_addr;
  logic [Q30_W-1:0]    rom_data;

  logic [FREQ_W-1:0]   freq_now;
  logic [SUM_W-1:0]    freq_up;
  logic [SUM_W-1:0]    freq_upd;
  logic [TOP_W+IDX_W-1:0] idx_scaled;
  logic [1:0]          quad;
  logic [IDX_W-1:0]    quad_rem;
  logic [ADDR_W-1:0]   rem_addr;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] sample_val;
  logic [PHASE_BITS-1:0] phase_next;

  stg_state_mem #(
    .DATA_W    (DATA_W),
    .FREQ_INIT (FREQ_INIT)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  stg_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  stg_divider #(
    .NUM_W (NUM_W),
    .DEN_W (RATE_W),
    .QUO_W (PHASE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({freq_r, {SHIFT_W{1'b0}}}),
    .divisor  (rate_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_accept     = in_beat.valid && in_beat.ready;
  assign in_beat.ready = (state_r == ST_IDLE);
  assign out_free      = !out_valid_r || out_beat.ready;

  // pitch adjust: raise and clamp high, then lower and clamp low
  assign freq_now = mem_rd_data[FREQ_W-1:0];

  always_comb begin
    freq_up = SUM_W'(freq_now);
    if (up_r != '0) begin
      freq_up = SUM_W'(freq_now) + SUM_W'(up_r);
      if (freq_up > FREQ_MAX) begin
        freq_up = FREQ_MAX;
      end
    end
    freq_upd = freq_up;
    if (down_r != '0) begin
      if (freq_up < SUM_W'(down_r) + FREQ_MIN) begin
        freq_upd = FREQ_MIN;
      end else begin
        freq_upd = freq_up - SUM_W'(down_r);
      end
    end
  end

  // table index from the top 16 phase bits
  assign idx_scaled = {{IDX_W{1'b0}}, phase_r[PHASE_BITS-1 -: TOP_W]} * IDX_SCALE;

  always_comb begin
    quad     = 2'd0;
    quad_rem = idx_r;
    if (idx_r >= QUAD3) begin
      quad     = 2'd3;
      quad_rem = idx_r - QUAD3;
    end else if (idx_r >= QUAD2) begin
      quad     = 2'd2;
      quad_rem = idx_r - QUAD2;
    end else if (idx_r >= QUAD1) begin
      quad     = 2'd1;
      quad_rem = idx_r - QUAD1;
    end
    rem_addr = quad_rem[ADDR_W-1:0];
    // odd quadrants run the table backward
    rom_addr = quad[0] ? (DEPTH_A - rem_addr) : rem_addr;
  end

  assign mag        = prod_r[Q30_FRAC +: SAMPLE_W];
  assign sample_val = neg_r ? (~mag + 1'b1) : mag;
  assign phase_next = phase_r + div_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mem_rd_addr = ENTRY_FREQ;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ENTRY_FREQ;
    mem_wr_data = '0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RD_FREQ;
        end
      end
      ST_RD_FREQ: begin
        if (cmd_r == CMD_PITCH) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = ENTRY_FREQ;
          mem_wr_data = DATA_W'(freq_upd);
          state_nxt   = ST_IDLE;
        end else begin
          mem_rd_addr = ENTRY_PHASE;
          state_nxt   = ST_RD_PHASE;
        end
      end
      ST_RD_PHASE: begin
        div_start = 1'b1;
        state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (div_done && out_free) begin
          out_load    = 1'b1;
          mem_wr_en   = 1'b1;
          mem_wr_addr = ENTRY_PHASE;
          mem_wr_data = DATA_W'(phase_next);
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_beat.command;
      up_r   <= in_beat.pitch_up;
      down_r <= in_beat.pitch_down;
    end
    if (state_r == ST_RD_FREQ) begin
      freq_r <= freq_now;
    end
    if (state_r == ST_RD_PHASE) begin
      phase_r <= mem_rd_data[PHASE_BITS-1:0];
    end
    if (state_r == ST_LOOKUP) begin
      idx_r <= idx_scaled[TOP_W +: IDX_W];
    end
    if (state_r == ST_ADDR) begin
      neg_r <= quad[1];
    end
    if (state_r == ST_SCALE) begin
      prod_r <= MUL_W'(rom_data) * MUL_W'(vol_r);
    end
    if (out_load) begin
      out_sample_r <= sample_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      vol_r  <= VOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_TONE_VOLUME: vol_r  <= cfg_wdata[VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.left_sample  = out_sample_r;
  assign out_beat.right_sample = out_sample_r;

endmodule

@@ test/sine_tone_generator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_generator_unit_test
// Drives generate and pitch beats into the tone generator under changing
// sample rate and volume settings, predicts every stereo frame from its own
// copy of the phase, frequency and sine table, and checks each frame in order.
// ----------------------------------------------------------------------------
module sine_tone_generator_unit_test;
  import stg_pkg::*;

  localparam int TABLE_DEPTH     = 1024;
  localparam int PHASE_W         = 32;
  localparam int FREQ_FRAC       = 4;
  localparam int DRAIN_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SEGMENTS        = 6;
  localparam int SEGMENT_BEATS   = 110;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam int unsigned FREQ_TOP    = FREQ_MAX_HZ << FREQ_FRAC;
  localparam int unsigned FREQ_BOTTOM = FREQ_MIN_HZ << FREQ_FRAC;
  localparam int unsigned FREQ_START  = FREQ_RESET_HZ << FREQ_FRAC;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_TONE_VOLUME + 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    cmd_t                       cmd;
    logic [PITCH_W-1:0]         up;
    logic [PITCH_W-1:0]         down;
    bit                         fixed;
    logic signed [SAMPLE_W-1:0] level;
    logic [CFG_INDEX_W-1:0]     index;
    logic [CFG_DATA_W-1:0]      wdata;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  stg_in_if  in_ch ();
  stg_out_if out_ch ();

  always #10 clk = ~clk;

  sine_tone_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_ch),
    .out_beat  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // tone state as the block should hold it
  longint             quarter_wave [0:TABLE_DEPTH];
  logic [PHASE_W-1:0] model_phase;
  int unsigned        model_freq;
  logic [RATE_W-1:0]  model_rate;
  logic [VOL_W-1:0]   model_volume;

  frame_t pending_frames [$];
  row_t   directed_rows [$];
  int     error_count   = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_left     = 0;

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Returns 1 when the beat yields a frame; updates the tone state either way.
  function automatic bit advance_tone(input cmd_t cmd, input logic [PITCH_W-1:0] up,
                                      input logic [PITCH_W-1:0] down, output frame_t fr);
    int unsigned       f;
    logic [15:0]       p;
    longint unsigned   idx;
    int                quad;
    int                r;
    longint            s;
    longint            scaled;
    logic [63:0]       phase_step;
    fr = '0;
    if (cmd == CMD_PITCH) begin
      f = model_freq;
      if (up != 0) begin
        f = f + up;
        if (f > FREQ_TOP) begin
          f = FREQ_TOP;
        end
      end
      if (down != 0) begin
        if (f < down + FREQ_BOTTOM) begin
          f = FREQ_BOTTOM;
        end else begin
          f = f - down;
        end
      end
      model_freq = f;
      return 1'b0;
    end
    p    = model_phase[PHASE_W-1 -: 16];
    idx  = (64'(p) * (4 * TABLE_DEPTH)) >> 16;
    quad = int'((idx / TABLE_DEPTH) % 4);
    r    = int'(idx % TABLE_DEPTH);
    // odd quadrants read the table backwards, the lower half is negated
    s = (quad % 2 == 0) ? quarter_wave[r] : quarter_wave[TABLE_DEPTH - r];
    if (quad >= 2) begin
      s = -s;
    end
    scaled   = (s * longint'(model_volume)) / ONE_Q30;
    fr.left  = scaled[SAMPLE_W-1:0];
    fr.right = scaled[SAMPLE_W-1:0];
    if (model_rate == 0) begin
      phase_step = '0;
    end else begin
      phase_step = (64'(model_freq) << (PHASE_W - FREQ_FRAC)) / 64'(model_rate);
    end
    model_phase = model_phase + phase_step[PHASE_W-1:0];
    return 1'b1;
  endfunction

  function automatic row_t beat_row(cmd_t cmd, logic [PITCH_W-1:0] up,
                                    logic [PITCH_W-1:0] down, bit fixed,
                                    logic signed [SAMPLE_W-1:0] level);
    row_t row;
    row.kind  = ROW_BEAT;
    row.cmd   = cmd;
    row.up    = up;
    row.down  = down;
    row.fixed = fixed;
    row.level = level;
    row.index = '0;
    row.wdata = '0;
    return row;
  endfunction

  function automatic row_t cfg_row(logic [CFG_INDEX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] wdata);
    row_t row;
    row.kind  = ROW_WRITE;
    row.cmd   = CMD_GENERATE;
    row.up    = '0;
    row.down  = '0;
    row.fixed = 1'b0;
    row.level = '0;
    row.index = index;
    row.wdata = wdata;
    return row;
  endfunction

  task automatic send_beat(cmd_t cmd, logic [PITCH_W-1:0] up, logic [PITCH_W-1:0] down,
                           bit fixed, logic signed [SAMPLE_W-1:0] level);
    frame_t fr;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.pitch_up   <= up;
    in_ch.pitch_down <= down;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (advance_tone(cmd, up, down, fr)) begin
      if (fixed) begin
        fr.left  = level;
        fr.right = level;
      end
      pending_frames.push_back(fr);
    end
  endtask

  task automatic wait_frames_out();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] wdata);
    wait_frames_out();
    // a pitch beat may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_SAMPLE_RATE: model_rate   = wdata[RATE_W-1:0];
      CFG_TONE_VOLUME: model_volume = wdata[VOL_W-1:0];
      default: ;
    endcase
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : frame_check
    frame_t got;
    frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.left  = out_ch.left_sample;
      got.right = out_ch.right_sample;
      if (pending_frames.size() == 0) begin
        report_error($sformatf("unexpected frame L=%0d R=%0d", got.left, got.right));
      end else begin
        want = pending_frames.pop_front();
        if (got.left !== want.left || got.right !== want.right) begin
          report_error($sformatf("frame mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 want.left, want.right, got.left, got.right));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    longint                 x;
    longint                 t;
    longint                 acc;
    int                     k;
    int                     n;
    int                     seg;
    int                     beat;
    cmd_t                   cmd;
    logic [PITCH_W-1:0]     up;
    logic [PITCH_W-1:0]     down;
    logic [RATE_W-1:0]      rate_pick;
    logic [CFG_DATA_W-1:0]  vol_pick;
    logic [CFG_INDEX_W-1:0] spare_index;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_GENERATE;
    in_ch.pitch_up   <= '0;
    in_ch.pitch_down <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_SAMPLE_RATE;
    cfg_wdata        <= '0;

    // Taylor series to x^15, truncating toward zero after every product
    for (k = 0; k <= TABLE_DEPTH; k++) begin
      x   = (longint'(k) * HALF_PI_Q30) / TABLE_DEPTH;
      t   = x;
      acc = x;
      for (n = 1; n <= 7; n++) begin
        t   = (t * x) / ONE_Q30;
        t   = (t * x) / ONE_Q30;
        t   = -t / longint'(2 * n * (2 * n + 1));
        acc = acc + t;
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > ONE_Q30) begin
        acc = ONE_Q30;
      end
      quarter_wave[k] = acc;
    end
    model_phase  = '0;
    model_freq   = FREQ_START;
    model_rate   = RATE_RESET;
    model_volume = VOL_RESET;

    // full volume and a rate giving a quarter-cycle step at 440 Hz: walks the
    // quadrant boundaries and wraps back to zero phase
    directed_rows.push_back(cfg_row(CFG_TONE_VOLUME, 18'd32767));
    directed_rows.push_back(cfg_row(CFG_SAMPLE_RATE, 18'd1760));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b1, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'hfff, 12'hfff, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b1, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'haaa, 12'h555, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h555, 12'haaa, 1'b1, 16'sd0));
    // zero rate: phase holds
    directed_rows.push_back(cfg_row(CFG_SAMPLE_RATE, 18'd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b0, 16'sd0));
    // silent, and a rate below the tone so the step exceeds a cycle
    directed_rows.push_back(cfg_row(CFG_TONE_VOLUME, 18'd0));
    directed_rows.push_back(cfg_row(CFG_SAMPLE_RATE, 18'd100));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b1, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'hfff, 12'h000, 1'b1, 16'sd0));
    directed_rows.push_back(cfg_row(CFG_TONE_VOLUME, CFG_DATA_W'(VOL_RESET)));
    directed_rows.push_back(cfg_row(CFG_SAMPLE_RATE, CFG_DATA_W'(RATE_RESET)));
    // pitch: no-op, clamp high, clamp low, both at once
    directed_rows.push_back(beat_row(CMD_PITCH, 12'h000, 12'h000, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'hfff, 12'h000, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'hfff, 12'h000, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'h000, 12'hfff, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'h000, 12'hfff, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'h000, 12'hfff, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'hfff, 12'hfff, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'haaa, 12'h555, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_PITCH, 12'h555, 12'haaa, 1'b0, 16'sd0));
    directed_rows.push_back(beat_row(CMD_GENERATE, 12'h000, 12'h000, 1'b0, 16'sd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_register(directed_rows[i].index, directed_rows[i].wdata);
      end else begin
        send_beat(directed_rows[i].cmd, directed_rows[i].up, directed_rows[i].down,
                  directed_rows[i].fixed, directed_rows[i].level);
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin
          rate_pick = 18'd8000;
          vol_pick  = 18'd32767;
        end
        1: begin
          rate_pick = 18'd192000;
          vol_pick  = CFG_DATA_W'($urandom);
        end
        2: begin
          rate_pick = '1;
          vol_pick  = CFG_DATA_W'($urandom_range(0, 32767));
        end
        3: begin
          rate_pick = RATE_W'($urandom_range(8000, 192000));
          vol_pick  = 18'd1;
        end
        4: begin
          rate_pick = RATE_W'($urandom);
          vol_pick  = CFG_DATA_W'($urandom);
        end
        default: begin
          rate_pick = RATE_RESET;
          vol_pick  = CFG_DATA_W'(VOL_RESET);
        end
      endcase
      spare_index = CFG_FIRST_UNUSED + CFG_INDEX_W'($urandom_range(0, 13));
      write_register(CFG_SAMPLE_RATE, CFG_DATA_W'(rate_pick));
      write_register(CFG_TONE_VOLUME, vol_pick);
      write_register(spare_index, CFG_DATA_W'($urandom));

      if (seg < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 68;
      end else if (seg < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (beat = 0; beat < SEGMENT_BEATS; beat++) begin
        // back up the block with the input still offered
        if (seg == 4 && beat == 5) begin
          hold_left = HOLD_OFF_CYCLES;
        end
        if (seg % 2 == 0 && beat == 60) begin
          wait_frames_out();
        end
        cmd  = ($urandom_range(0, 3) == 0) ? CMD_PITCH : CMD_GENERATE;
        up   = ($urandom_range(0, 7) == 0) ? '0 :
               ($urandom_range(0, 7) == 0) ? '1 : PITCH_W'($urandom);
        down = ($urandom_range(0, 7) == 0) ? '0 :
               ($urandom_range(0, 7) == 0) ? '1 : PITCH_W'($urandom);
        send_beat(cmd, up, down, 1'b0, '0);
      end
    end

    wait_frames_out();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_frames.size() != 0) begin
      report_error($sformatf("%0d frames never arrived", pending_frames.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
